// ===== hdl/activity_indicator_hold_release_defines.svh =====
// ----------------------------------------------------------------------------
// Activity indicator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACTIVITY_INDICATOR_HOLD_RELEASE_DEFINES_SVH
`define ACTIVITY_INDICATOR_HOLD_RELEASE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AIHR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("activity indicator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AIHR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("activity indicator assertion failed");

`endif

// ===== hdl/aihr_pkg.sv =====
// ----------------------------------------------------------------------------
// Activity indicator package
// Constants, register indexes, event codes and stream field positions.
// ----------------------------------------------------------------------------
`default_nettype none

package aihr_pkg;

	// Default parameter values.
	localparam int PIN_COUNT_DEF = 4;
	localparam int TIME_BITS_DEF = 32;

	// Pins that have a byte in the pin map and show in the result.
	localparam int MAP_PINS = 4;

	// Configuration port.
	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLED = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RX_HOLD = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TX_HOLD = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PIN_MAP = 2'd3;
	localparam int HOLD_W = 16;
	localparam int MAP_W  = 32;

	// Event kinds carried in tuser.
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_RX      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TX      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd3;

	// Input tdata layout.
	localparam int CHAN_W      = 3;
	localparam int NOW_IN_W    = 32;
	localparam int IN_CHAN_LSB = 0;
	localparam int IN_ACT_BIT  = 3;
	localparam int IN_QUAL_BIT = 4;
	localparam int IN_NOW_LSB  = 5;
	localparam int IN_TDATA_W  = 40;

	// Output tdata layout: line levels, asserted mask, pending mask.
	localparam int MASK_W      = 4;
	localparam int OUT_FIELD_W = 3 * MASK_W;
	localparam int OUT_TDATA_W = 16;

endpackage

`default_nettype wire

// ===== hdl/activity_indicator_hold_release.sv =====
// ----------------------------------------------------------------------------
// Activity indicator with hold and release
// Drives active-low status pins from receive and transmit channel events.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while results are taken, and each event
// gives one result that reports the pin state after it. The event waits in the
// input register until the pin update logic fills the result register from it:
// a channel match per pin, two shared adds for the rx and tx deadlines and one
// wrap-safe compare per pin. When the result is stalled, one more event waits
// in the input register, and the input then stalls until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module activity_indicator_hold_release #(
	parameter int PIN_COUNT = aihr_pkg::PIN_COUNT_DEF,
	parameter int TIME_BITS = aihr_pkg::TIME_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [aihr_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire logic [aihr_pkg::CFG_W-1:0]        cfg_data,
	// Event stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// channel[2:0], active[3], qualified[4], now_ms[36:5], zero fill
	input  wire logic [aihr_pkg::IN_TDATA_W-1:0]   s_tdata,
	// mode[1:0]
	input  wire logic [aihr_pkg::MODE_W-1:0]       s_tuser,
	// Result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// line_levels[3:0], asserted_mask[7:4], pending_mask[11:8], zero fill
	output logic [aihr_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	localparam int NOW_W = (TIME_BITS < aihr_pkg::NOW_IN_W) ? TIME_BITS : aihr_pkg::NOW_IN_W;

	// Configuration registers.
	logic                          enabled_q;
	logic [aihr_pkg::HOLD_W-1:0]   rx_hold_q;
	logic [aihr_pkg::HOLD_W-1:0]   tx_hold_q;
	logic [aihr_pkg::MAP_W-1:0]    pin_map_q;

	// Input stage.
	logic                          valid_s1;
	logic [aihr_pkg::MODE_W-1:0]   mode_s1;
	logic [aihr_pkg::CHAN_W-1:0]   chan_s1;
	logic                          act_s1;
	logic                          qual_s1;
	logic [aihr_pkg::NOW_IN_W-1:0] now_s1;

	// Pin state.
	logic [PIN_COUNT-1:0]          asserted_q;
	logic [PIN_COUNT-1:0]          pending_q;
	logic [TIME_BITS-1:0]          deadline_q [PIN_COUNT];
	logic [PIN_COUNT-1:0]          asserted_nx;
	logic [PIN_COUNT-1:0]          pending_nx;
	logic [PIN_COUNT-1:0]          sched_en;
	logic [PIN_COUNT-1:0]          use_rx;

	// Result register.
	logic                          m_tvalid_q;
	logic [aihr_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic                          advance;
	logic                          fire;
	logic [TIME_BITS-1:0]          now_t;
	logic [TIME_BITS-1:0]          dl_rx;
	logic [TIME_BITS-1:0]          dl_tx;
	logic [aihr_pkg::MASK_W-1:0]   res_levels;
	logic [aihr_pkg::MASK_W-1:0]   res_asserted;
	logic [aihr_pkg::MASK_W-1:0]   res_pending;

	// Handshake: the result register moves when empty or taken.
	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			rx_hold_q <= '0;
			tx_hold_q <= '0;
			pin_map_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aihr_pkg::REG_ENABLED: enabled_q <= cfg_data[0];
				aihr_pkg::REG_RX_HOLD: rx_hold_q <= cfg_data[aihr_pkg::HOLD_W-1:0];
				aihr_pkg::REG_TX_HOLD: tx_hold_q <= cfg_data[aihr_pkg::HOLD_W-1:0];
				aihr_pkg::REG_PIN_MAP: pin_map_q <= cfg_data[aihr_pkg::MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload, loaded on each input transfer.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			chan_s1 <= s_tdata[aihr_pkg::IN_CHAN_LSB +: aihr_pkg::CHAN_W];
			act_s1  <= s_tdata[aihr_pkg::IN_ACT_BIT];
			qual_s1 <= s_tdata[aihr_pkg::IN_QUAL_BIT];
			now_s1  <= s_tdata[aihr_pkg::IN_NOW_LSB +: aihr_pkg::NOW_IN_W];
		end
	end

	// Time of the event in the deadline width, and the two candidate deadlines.
	assign now_t = TIME_BITS'(now_s1[NOW_W-1:0]);
	assign dl_rx = now_t + TIME_BITS'(rx_hold_q);
	assign dl_tx = now_t + TIME_BITS'(tx_hold_q);

	// Per-pin event handling.
	for (genvar g = 0; g < PIN_COUNT; g++) begin : g_pin
		logic [7:0]           map_b;
		logic                 rx_hit;
		logic                 tx_hit;
		logic                 do_assert;
		logic                 do_sched;
		logic                 do_release;
		logic [TIME_BITS-1:0] diff;

		if (g < aihr_pkg::MAP_PINS) begin : g_map
			assign map_b = pin_map_q[8*g +: 8];
		end else begin : g_nomap
			assign map_b = 8'h00;
		end

		assign use_rx[g] = map_b[7];
		assign diff      = now_t - deadline_q[g];

		always_comb begin
			rx_hit     = enabled_q && (mode_s1 == aihr_pkg::MODE_RX) && map_b[7]
				&& (map_b[6:4] == chan_s1);
			tx_hit     = enabled_q && (mode_s1 == aihr_pkg::MODE_TX) && map_b[3]
				&& (map_b[2:0] == chan_s1);
			do_assert  = (rx_hit && act_s1 && qual_s1) || (tx_hit && act_s1);
			do_sched   = asserted_q[g]
				&& ((rx_hit && !(act_s1 && qual_s1)) || (tx_hit && !act_s1));
			do_release = enabled_q && ((mode_s1 == aihr_pkg::MODE_RELEASE)
				|| ((mode_s1 == aihr_pkg::MODE_TICK) && pending_q[g]
				&& !diff[TIME_BITS-1]));

			asserted_nx[g] = asserted_q[g];
			pending_nx[g]  = pending_q[g];
			if (do_assert) begin
				asserted_nx[g] = 1'b1;
				pending_nx[g]  = 1'b0;
			end else if (do_sched) begin
				pending_nx[g]  = 1'b1;
			end else if (do_release) begin
				asserted_nx[g] = 1'b0;
				pending_nx[g]  = 1'b0;
			end
			sched_en[g] = do_sched;
		end

		// Pin flags.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				asserted_q[g] <= 1'b0;
				pending_q[g]  <= 1'b0;
			end else if (fire) begin
				asserted_q[g] <= asserted_nx[g];
				pending_q[g]  <= pending_nx[g];
			end
		end

		// Release deadline, only read while pending.
		always_ff @(posedge clk) begin
			if (fire && sched_en[g]) begin
				deadline_q[g] <= use_rx[g] ? dl_rx : dl_tx;
			end
		end
	end

	// Result fields for the pins that are shown.
	for (genvar o = 0; o < aihr_pkg::MASK_W; o++) begin : g_res
		if (o < PIN_COUNT) begin : g_live
			assign res_levels[o]   = !asserted_nx[o];
			assign res_asserted[o] = asserted_nx[o];
			assign res_pending[o]  = pending_nx[o];
		end else begin : g_none
			assign res_levels[o]   = 1'b0;
			assign res_asserted[o] = 1'b0;
			assign res_pending[o]  = 1'b0;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= aihr_pkg::OUT_TDATA_W'({res_pending, res_asserted, res_levels});
		end
	end

endmodule

`default_nettype wire

// ===== hdl/aihr_checker.sv =====
// ----------------------------------------------------------------------------
// Activity indicator port checker
// Watches the top-level ports for consistent results and transfer ordering.
// ----------------------------------------------------------------------------
`default_nettype none

`include "activity_indicator_hold_release_defines.svh"

module aihr_checker #(
	parameter int PIN_COUNT = aihr_pkg::PIN_COUNT_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [aihr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int SHOWN = (PIN_COUNT < aihr_pkg::MASK_W) ? PIN_COUNT : aihr_pkg::MASK_W;
	localparam logic [aihr_pkg::MASK_W-1:0] PIN_MASK = aihr_pkg::MASK_W'((1 << SHOWN) - 1);

	// Items accepted whose result has not been transferred yet.
	logic [1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else begin
			inflight_q <= inflight_q + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
		end
	end

	// A pending release only exists on an asserted pin.
	`AIHR_ASSERT_IMP(a_pend_on_asrt, m_tvalid, (m_tdata[11:8] & ~m_tdata[7:4]) == 4'b0000)
	// A shown pin is low exactly when asserted.
	`AIHR_ASSERT_IMP(a_level_vs_asrt, m_tvalid, (m_tdata[3:0] ^ m_tdata[7:4]) == PIN_MASK)
	// A stalled result stays put.
	`AIHR_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// Every result stems from an accepted item.
	`AIHR_ASSERT_IMP(a_out_has_src, m_tvalid, inflight_q != 2'd0)
	// No more than two items are held between the ports.
	`AIHR_ASSERT_IMP(a_inflight_cap, s_tvalid && s_tready && !m_tready, inflight_q != 2'd2)

endmodule

bind activity_indicator_hold_release aihr_checker #(.PIN_COUNT(PIN_COUNT)) u_aihr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
